// ===== hw/rtl/dltq_pkg.sv =====
// Shared types and constants of the delta-list timer queue.
package dltq_pkg;

	localparam int IDX_W = 6;
	localparam logic [IDX_W-1:0] IDX_NONE = 6'd63;
	localparam int RUN_W = 5;
	localparam logic [RUN_W-1:0] RUN_LAST = 5'd31;
	localparam int PAY_W = 80;

	localparam logic OP_SCHEDULE = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	localparam logic [1:0] STAT_SCHEDULED = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_EXPIRED   = 2'd2;
	localparam logic [1:0] STAT_NO_EXPIRY = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [31:0] delay;
		logic [31:0] handler;
		logic [15:0] kind_tag;
		logic [31:0] context_req;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCHED, ST_SFREE, ST_FRONT, ST_WALK1, ST_WALK2,
		ST_INS, ST_INS2, ST_DONE, ST_TICK, ST_EXP1, ST_EXP2
	} state_t;

	// Link value of an entry that was never written since reset.
	function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		r = (idx == '0) ? IDX_NONE : idx - 1'b1;
		return r;
	endfunction

endpackage

// ===== hw/rtl/dltq_req_if.sv =====
// Request channel: schedule or tick items.
interface dltq_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] delay;
	logic [31:0] handler;
	logic [15:0] kind_tag;
	logic [31:0] context_req;

	modport source(output valid, operation, delay, handler, kind_tag, context_req,
		input ready);
	modport sink(input valid, operation, delay, handler, kind_tag, context_req,
		output ready);
endinterface

// ===== hw/rtl/dltq_rsp_if.sv =====
// Response channel: result items.
interface dltq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] out_handler;
	logic [15:0] out_kind;
	logic [31:0] out_context;
	logic        last;

	modport source(output valid, status, out_handler, out_kind, out_context, last,
		input ready);
	modport sink(input valid, status, out_handler, out_kind, out_context, last,
		output ready);
endinterface

// ===== hw/rtl/dltq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dltq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/dltq_front.sv =====
// Front end: accepts items, normalizes the delay and queues them for the sequencer.
module dltq_front (
	input  logic               clk,
	input  logic               arst_n,
	dltq_req_if.sink           req,
	output dltq_pkg::cmdq_t    head,
	input  logic               pop
);
	import dltq_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       in_cmd;

	assign req.ready = (count_q != 2'd2);
	assign push = req.valid && req.ready;

	always_comb begin
		in_cmd.operation   = req.operation;
		// A zero delay behaves as one tick.
		in_cmd.delay       = (req.delay == '0) ? 32'd1 : req.delay;
		in_cmd.handler     = req.handler;
		in_cmd.kind_tag    = req.kind_tag;
		in_cmd.context_req = req.context_req;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = slot_q[rd_ptr_q];
endmodule

// ===== hw/rtl/dltq_back.sv =====
// Back end: list sequencer over the entry memories, with the result register.
module dltq_back #(
	parameter int ENTRIES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dltq_pkg::cmdq_t   head,
	output logic              pop,
	dltq_rsp_if.source        rsp
);
	import dltq_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [IDX_W-1:0] e_q, cur_q, nxt_q, active_q, free_q;
	logic [31:0] rem_q, hr_q;
	logic [RUN_W-1:0] cnt_q;
	logic lvalid_q [ENTRIES];
	logic lrd_valid_q;
	logic [IDX_W-1:0] lrd_addr_q;

	logic ovalid_q, olast_q;
	logic [1:0] ostatus_q;
	logic [PAY_W-1:0] opay_q;

	logic link_we, link_re, delta_we, delta_re, pay_we, pay_re;
	logic [IDX_W-1:0] link_waddr, link_raddr, delta_waddr, delta_raddr, pay_waddr, pay_raddr;
	logic [IDX_W-1:0] link_wdata, link_rdata, link_val;
	logic [31:0] delta_wdata, delta_rdata;
	logic [PAY_W-1:0] pay_rdata;

	logic can_emit, emit, emit_last;
	logic [1:0] emit_status;
	logic d_lt_hr, nd_gt_rem, tick_quiet, cont;

	assign link_val  = lrd_valid_q ? link_rdata : reset_link(lrd_addr_q);
	assign can_emit  = !ovalid_q || rsp.ready;
	assign d_lt_hr   = cmd_q.delay < hr_q;
	assign nd_gt_rem = delta_rdata > rem_q;
	assign tick_quiet = (active_q == IDX_NONE) || (hr_q > 32'd1);
	assign cont = (nxt_q != IDX_NONE) && (delta_rdata == '0) && (cnt_q != RUN_LAST);

	dltq_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr[AW-1:0]), .wdata(link_wdata),
		.re(link_re), .raddr(link_raddr[AW-1:0]), .rdata(link_rdata));

	dltq_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_delta (
		.clk(clk), .we(delta_we), .waddr(delta_waddr[AW-1:0]), .wdata(delta_wdata),
		.re(delta_re), .raddr(delta_raddr[AW-1:0]), .rdata(delta_rdata));

	dltq_ram #(.WIDTH(PAY_W), .DEPTH(ENTRIES)) u_pay (
		.clk(clk), .we(pay_we), .waddr(pay_waddr[AW-1:0]),
		.wdata({cmd_q.handler, cmd_q.kind_tag, cmd_q.context_req}),
		.re(pay_re), .raddr(pay_raddr[AW-1:0]), .rdata(pay_rdata));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					state_d = (head.cmd.operation == OP_SCHEDULE) ? ST_SCHED : ST_TICK;
				end
			end
			ST_SCHED: begin
				if (free_q != IDX_NONE) begin
					state_d = ST_SFREE;
				end else if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_SFREE: begin
				if (active_q == IDX_NONE) begin
					state_d = ST_DONE;
				end else if (d_lt_hr) begin
					state_d = ST_FRONT;
				end else begin
					state_d = ST_WALK1;
				end
			end
			ST_FRONT: state_d = ST_DONE;
			ST_WALK1: state_d = (link_val == IDX_NONE) ? ST_INS : ST_WALK2;
			ST_WALK2: state_d = nd_gt_rem ? ST_INS : ST_WALK1;
			ST_INS:   state_d = ST_INS2;
			ST_INS2:  state_d = ST_DONE;
			ST_DONE: begin
				if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (!tick_quiet) begin
					state_d = ST_EXP1;
				end else if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			ST_EXP1: state_d = ST_EXP2;
			ST_EXP2: begin
				if (can_emit) begin
					state_d = cont ? ST_EXP1 : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls and result strobes.
	always_comb begin
		pop = 1'b0;
		link_we = 1'b0; link_waddr = e_q; link_wdata = IDX_NONE;
		link_re = 1'b0; link_raddr = active_q;
		delta_we = 1'b0; delta_waddr = e_q; delta_wdata = cmd_q.delay;
		delta_re = 1'b0; delta_raddr = link_val;
		pay_we = 1'b0; pay_waddr = free_q;
		pay_re = 1'b0; pay_raddr = active_q;
		emit = 1'b0; emit_last = 1'b1; emit_status = STAT_SCHEDULED;
		case (state_q)
			ST_IDLE: pop = head.valid;
			ST_SCHED: begin
				if (free_q != IDX_NONE) begin
					link_re = 1'b1; link_raddr = free_q;
					pay_we = 1'b1;
				end else begin
					emit = can_emit; emit_status = STAT_FULL;
				end
			end
			ST_SFREE: begin
				if (active_q == IDX_NONE) begin
					link_we = 1'b1;
					delta_we = 1'b1;
				end else if (d_lt_hr) begin
					delta_we = 1'b1; delta_waddr = active_q;
					delta_wdata = hr_q - cmd_q.delay;
				end else begin
					link_re = 1'b1;
				end
			end
			ST_FRONT: begin
				link_we = 1'b1; link_wdata = active_q;
				delta_we = 1'b1;
			end
			ST_WALK1: delta_re = (link_val != IDX_NONE);
			ST_WALK2: begin
				if (nd_gt_rem) begin
					delta_we = 1'b1; delta_waddr = nxt_q;
					delta_wdata = delta_rdata - rem_q;
				end else begin
					link_re = 1'b1; link_raddr = nxt_q;
				end
			end
			ST_INS: begin
				link_we = 1'b1; link_waddr = cur_q; link_wdata = e_q;
			end
			ST_INS2: begin
				link_we = 1'b1; link_wdata = nxt_q;
				delta_we = 1'b1; delta_wdata = rem_q;
			end
			ST_DONE: emit = can_emit;
			ST_TICK: begin
				if (tick_quiet) begin
					emit = can_emit; emit_status = STAT_NO_EXPIRY;
				end else begin
					link_re = 1'b1;
					pay_re = 1'b1;
				end
			end
			ST_EXP1: delta_re = (link_val != IDX_NONE);
			ST_EXP2: begin
				emit = can_emit; emit_status = STAT_EXPIRED; emit_last = !cont;
				if (can_emit) begin
					// Return the expired entry to the free list.
					link_we = 1'b1; link_waddr = active_q; link_wdata = free_q;
					if (cont) begin
						link_re = 1'b1; link_raddr = nxt_q;
						pay_re = 1'b1; pay_raddr = nxt_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
		end
		if (emit) begin
			opay_q <= (emit_status == STAT_EXPIRED) ? pay_rdata : '0;
			ostatus_q <= emit_status;
			olast_q <= emit_last;
		end
		if (link_re) begin
			lrd_addr_q <= link_raddr;
		end
		case (state_q)
			ST_SCHED: e_q <= free_q;
			ST_SFREE: begin
				rem_q <= cmd_q.delay - hr_q;
				cur_q <= active_q;
			end
			ST_WALK1: nxt_q <= link_val;
			ST_WALK2: begin
				if (!nd_gt_rem) begin
					rem_q <= rem_q - delta_rdata;
					cur_q <= nxt_q;
				end
			end
			ST_EXP1: nxt_q <= link_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
			active_q <= IDX_NONE;
			free_q <= IDX_W'(ENTRIES - 1);
			hr_q <= '0;
			cnt_q <= '0;
			lrd_valid_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				lvalid_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			if (link_re) begin
				lrd_valid_q <= lvalid_q[link_raddr[AW-1:0]];
			end
			if (link_we) begin
				lvalid_q[link_waddr[AW-1:0]] <= 1'b1;
			end
			case (state_q)
				ST_SFREE: begin
					free_q <= link_val;
					if (active_q == IDX_NONE) begin
						active_q <= e_q;
						hr_q <= cmd_q.delay;
					end
				end
				ST_FRONT: begin
					active_q <= e_q;
					hr_q <= cmd_q.delay;
				end
				ST_TICK: begin
					if (tick_quiet) begin
						if (can_emit && active_q != IDX_NONE) begin
							hr_q <= hr_q - 32'd1;
						end
					end else begin
						cnt_q <= '0;
					end
				end
				ST_EXP2: begin
					if (can_emit) begin
						free_q <= active_q;
						active_q <= nxt_q;
						cnt_q <= cnt_q + 1'b1;
						if (!cont) begin
							hr_q <= (nxt_q != IDX_NONE) ? delta_rdata : '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign rsp.valid = ovalid_q;
	assign rsp.status = ostatus_q;
	assign rsp.out_handler = opay_q[79:48];
	assign rsp.out_kind = opay_q[47:32];
	assign rsp.out_context = opay_q[31:0];
	assign rsp.last = olast_q;

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == ST_IDLE)
		else $error("final result did not return the sequencer to idle");

	a_lists_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		active_q != IDX_NONE |-> active_q != free_q)
		else $error("an entry heads both the active and the free list");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE && head.valid)
		else $error("command taken while the sequencer was busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !ovalid_q || rsp.ready)
		else $error("result register overwritten before transfer");
endmodule

// ===== hw/rtl/delta_list_timer_queue.sv =====
// Delta-list timer queue top level: request front end, list sequencer, result register.
// A pool of ENTRIES timers is kept as a delta-encoded sorted list in three small RAMs
// (links, deltas, payload words) walked by one sequencer. A schedule walks past the
// active entries that expire no later than it; an expiring tick emits one result per
// expired entry of the run. A two-deep request queue lets the next items be accepted
// while the sequencer works and results wait for transfer.
module delta_list_timer_queue #(
	parameter int ENTRIES = 32
) (
	input logic       clk,
	input logic       arst_n,
	dltq_req_if.sink  req,
	dltq_rsp_if.source rsp
);
	import dltq_pkg::*;

	cmdq_t head;
	logic  pop;

	dltq_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .head(head), .pop(pop));

	dltq_back #(.ENTRIES(ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .pop(pop), .rsp(rsp));
endmodule

// ===== dv/dltq_scoreboard.sv =====
// Timer queue scoreboard: predicts result items from accepted requests and compares them.
`timescale 1ns / 100ps
module dltq_scoreboard #(
	parameter int ENTRIES = 32
) (
	input  logic clk,
	input  logic arst_n,
	dltq_req_if  req,
	dltq_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);
	import dltq_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] out_handler;
		logic [15:0] out_kind;
		logic [31:0] out_context;
		logic        last;
	} timer_result_t;

	localparam int MAX_RUN = 32;

	logic [IDX_W-1:0] nxt_link [64];
	logic [31:0]      delta    [64];
	logic [31:0]      tm_handler [64];
	logic [15:0]      tm_kind  [64];
	logic [31:0]      tm_context [64];
	logic [IDX_W-1:0] active_idx;
	logic [IDX_W-1:0] free_idx;
	logic [31:0]      head_left;

	timer_result_t expected_results[$];

	task automatic reset_model();
		for (int i = 0; i < 64; i++) begin
			nxt_link[i] = IDX_NONE;
			delta[i] = '0;
			tm_handler[i] = '0;
			tm_kind[i] = '0;
			tm_context[i] = '0;
		end
		for (int i = 1; i < ENTRIES; i++) nxt_link[i] = IDX_W'(i - 1);
		active_idx = IDX_NONE;
		free_idx = IDX_W'(ENTRIES - 1);
		head_left = '0;
		expected_results.delete();
		fail_count = 0;
	endtask

	function automatic timer_result_t mk(logic [1:0] st, logic [31:0] h, logic [15:0] k,
		logic [31:0] c, logic l);
		timer_result_t r;
		r.status = st;
		r.out_handler = h;
		r.out_kind = k;
		r.out_context = c;
		r.last = l;
		return r;
	endfunction

	task automatic schedule_timer(input cmd_t c);
		logic [31:0] d;
		logic [31:0] rem;
		logic [IDX_W-1:0] e, cur, nx;
		d = (c.delay == 0) ? 32'd1 : c.delay;
		e = free_idx;
		if (e == IDX_NONE) begin
			expected_results.push_back(mk(STAT_FULL, '0, '0, '0, 1'b1));
			return;
		end
		free_idx = nxt_link[e];
		tm_handler[e] = c.handler;
		tm_kind[e] = c.kind_tag;
		tm_context[e] = c.context_req;
		if (active_idx == IDX_NONE) begin
			nxt_link[e] = IDX_NONE;
			delta[e] = d;
			active_idx = e;
			head_left = d;
		end else if (d < head_left) begin
			delta[active_idx] = head_left - d;
			nxt_link[e] = active_idx;
			delta[e] = d;
			active_idx = e;
			head_left = d;
		end else begin
			rem = d - head_left;
			cur = active_idx;
			nx = IDX_NONE;
			for (int n = 0; n < ENTRIES; n++) begin
				nx = nxt_link[cur];
				if (nx == IDX_NONE) break;
				if (delta[nx] > rem) begin
					delta[nx] = delta[nx] - rem;
					break;
				end
				rem -= delta[nx];
				cur = nx;
			end
			nxt_link[cur] = e;
			nxt_link[e] = nx;
			delta[e] = rem;
		end
		expected_results.push_back(mk(STAT_SCHEDULED, '0, '0, '0, 1'b1));
	endtask

	task automatic tick_timers();
		int k;
		logic [IDX_W-1:0] e;
		timer_result_t r;
		k = 0;
		if (active_idx == IDX_NONE || head_left > 1) begin
			if (active_idx != IDX_NONE) head_left--;
			expected_results.push_back(mk(STAT_NO_EXPIRY, '0, '0, '0, 1'b1));
			return;
		end
		do begin
			e = active_idx;
			k++;
			active_idx = nxt_link[e];
			nxt_link[e] = free_idx;
			free_idx = e;
			r = mk(STAT_EXPIRED, tm_handler[e], tm_kind[e], tm_context[e], 1'b0);
			// mark the final entry of the run
			if (!(k < MAX_RUN && active_idx != IDX_NONE && delta[active_idx] == 0))
				r.last = 1'b1;
			expected_results.push_back(r);
		end while (!r.last);
		head_left = (active_idx != IDX_NONE) ? delta[active_idx] : 32'd0;
	endtask

	always @(posedge clk) begin
		timer_result_t got, exp_r;
		cmd_t c;
		if (!arst_n) begin
			reset_model();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = mk(rsp.status, rsp.out_handler, rsp.out_kind, rsp.out_context, rsp.last);
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer: status %0d", got.status);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.status != exp_r.status) begin
						$error("status: expected %0d, actual %0d", exp_r.status, got.status);
						fail_count++;
					end
					if (got.out_handler != exp_r.out_handler) begin
						$error("out_handler: expected %h, actual %h", exp_r.out_handler,
							got.out_handler);
						fail_count++;
					end
					if (got.out_kind != exp_r.out_kind) begin
						$error("out_kind: expected %h, actual %h", exp_r.out_kind, got.out_kind);
						fail_count++;
					end
					if (got.out_context != exp_r.out_context) begin
						$error("out_context: expected %h, actual %h", exp_r.out_context,
							got.out_context);
						fail_count++;
					end
					if (got.last != exp_r.last) begin
						$error("last: expected %0d, actual %0d", exp_r.last, got.last);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				c.operation = req.operation;
				c.delay = req.delay;
				c.handler = req.handler;
				c.kind_tag = req.kind_tag;
				c.context_req = req.context_req;
				if (c.operation == OP_TICK) tick_timers();
				else schedule_timer(c);
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== dv/tb_delta_list_timer_queue.sv =====
// Testbench top: drives schedule and tick requests, stalls the result side, reports the verdict.
`timescale 1ns / 100ps
module tb_delta_list_timer_queue;
	import dltq_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_pct;
	int   stall_pct;

	dltq_req_if req();
	dltq_rsp_if rsp();

	delta_list_timer_queue #(.ENTRIES(32)) uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	dltq_scoreboard #(.ENTRIES(32)) sb (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(negedge clk) rsp.ready <= ($urandom_range(99) >= stall_pct);

	// Insert idle cycles, present one request and hold it until the transfer.
	task automatic send(input logic op, input logic [31:0] d, input logic [31:0] h,
		input logic [15:0] k, input logic [31:0] c);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.delay <= d;
		req.handler <= h;
		req.kind_tag <= k;
		req.context_req <= c;
		// ready is stable at the falling edge; the next rising edge makes the transfer
		while (!req.ready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [31:0] d;
		if ($urandom_range(99) < 45) begin
			send(OP_TICK, $urandom, $urandom, 16'($urandom), $urandom);
		end else begin
			case ($urandom_range(63))
				0:       d = $urandom;
				1, 2, 3: d = 32'd0;
				default: d = $urandom_range(12);
			endcase
			send(OP_SCHEDULE, d, $urandom, 16'($urandom), $urandom);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.operation = OP_TICK;
		req.delay = '0;
		req.handler = '0;
		req.kind_tag = '0;
		req.context_req = '0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty tick, zero delay, extremes of the words
		send(OP_TICK, '0, '0, '0, '0);
		send(OP_SCHEDULE, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send(OP_TICK, '1, '0, '0, '0);
		send(OP_SCHEDULE, 32'd1, 32'h0, 16'h0, 32'h0);
		send(OP_TICK, '0, '0, '0, '0);
		// fill the pool with equal expiries, reject one, then expire a full run
		for (int i = 0; i < 32; i++) send(OP_SCHEDULE, 32'd2, i, 16'(i), ~i);
		send(OP_SCHEDULE, 32'hFFFF_FFFF, 32'h1234, 16'h55, 32'h77);
		send(OP_TICK, '0, '0, '0, '0);
		send(OP_TICK, '0, '0, '0, '0);
		// front insert, then a far entry behind it
		send(OP_SCHEDULE, 32'd5, $urandom, 16'($urandom), $urandom);
		send(OP_SCHEDULE, 32'd3, $urandom, 16'($urandom), $urandom);
		send(OP_SCHEDULE, 32'd5, $urandom, 16'($urandom), $urandom);
		send(OP_SCHEDULE, 32'hFFFF_FFFF, $urandom, 16'($urandom), $urandom);

		// hold off until every result is back
		req.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 50; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 50; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			for (int n = 0; n < 110; n++) send_random();
		end
		req.valid <= 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		wait (pending == 0);
		repeat (200) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** delta_list_timer_queue: PASSED **");
		else
			$display("** delta_list_timer_queue: FAILED **");
		$finish;
	end

	initial begin
		#30ms;
		$display("** delta_list_timer_queue: FAILED **");
		$finish;
	end

endmodule
